@@ rtl/lphm_pkg.sv @@
// shared types and codes for the linear probe hash map
package lphm_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic start;      // set probe index to the start slot
    logic step;       // advance probe index
    logic note_tomb;  // remember current index as first tombstone
    logic write_live; // write key/value, mark live at place
    logic write_val;  // write value at probe index
    logic write_tomb; // mark tombstone at probe index
    logic use_tomb;   // place is remembered tombstone
    logic count_up;
    logic count_down;
    logic set_result;
    logic [1:0] status;
    logic value_hit;  // take value_out from read data
  } lphm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic [1:0] mark;
    logic       key_match;
    logic       last_probe;
  } lphm_stat_t;

endpackage

@@ rtl/linear_probe_hash_map_top.sv @@
// Linear-probing hash map with tombstones.
// Request channel s_axis: tuser carries the command, tdata key, key hash and value.
// Result channel m_axis: one beat per request, tuser status, tdata value and entry count.
// Commands: insert/update, remove, lookup (code three acts as lookup).
// The start slot is key_hash modulo CAPACITY, formed by a registered reciprocal
// multiply; the probe then visits the slots in turn (registered memory read, then
// compare), stopping at the key, an empty slot, or after CAPACITY slots.
// After a request beat is accepted, the request is captured, the reciprocal product
// registered, the start slot set and the slots probed; a slot write passes through a
// write state of its own before the result beat is registered.
// One request at a time; the next request beat can be accepted on the edge where
// the result beat leaves.
// After reset every slot mark is cleared to empty in turn; s_axis_tready stays low
// through that sweep and until the controller has left its clear state.
// A result beat waits in its register while m_axis_tready is low; the next
// request is not taken until that beat has left.
module linear_probe_hash_map_top #(
  parameter int CAPACITY   = 32,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // key[31:0], key_hash[63:32], value_in[95:64]
  input  logic [1:0]   s_axis_tuser,  // command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // value_out[31:0], entry_count[37:32], zero pad
  output logic [1:0]   m_axis_tuser   // status
);

  lphm_pkg::lphm_cmd_t  cmd;
  lphm_pkg::lphm_stat_t stat;
  logic                 clear_done;
  logic [5:0]           entry_count;
  logic [31:0]          value_out;

  lphm_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .clear_done(clear_done), .stat(stat), .cmd(cmd)
  );

  lphm_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .command(s_axis_tuser), .key(s_axis_tdata[31:0]), .key_hash(s_axis_tdata[63:32]),
    .value_in(s_axis_tdata[95:64]),
    .cmd(cmd), .stat(stat), .clear_done(clear_done),
    .status(m_axis_tuser), .value_out(value_out), .entry_count(entry_count)
  );

  assign m_axis_tdata = {2'b00, entry_count, value_out};

endmodule

@@ rtl/lphm_ram.sv @@
// generic single-port-write ram with registered read
module lphm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lphm_ctrl.sv @@
// controller: probe sequencer for insert, remove and lookup
module lphm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   clear_done,
  input  lphm_pkg::lphm_stat_t   stat,
  output lphm_pkg::lphm_cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_HASH  = 3'd5;
  localparam logic [2:0] S_START = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       tomb_seen;
  logic       tomb_seen_next;
  logic       busy_out;

  assign busy_out  = out_valid && !out_ready;
  assign in_ready  = (state == S_IDLE) && !busy_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      tomb_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      tomb_seen <= tomb_seen_next;
      if (cmd.set_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next     = state;
    tomb_seen_next = tomb_seen;
    cmd            = '0;
    unique case (state)
      S_CLEAR: begin
        if (clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load       = 1'b1;
          tomb_seen_next = 1'b0;
          state_next     = S_HASH;
        end
      end
      S_HASH: begin
        // reciprocal product of the hash is registered
        state_next = S_START;
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        // memory read latency
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = S_READ;
        cmd.step   = 1'b1;
        if (stat.mark == lphm_pkg::MARK_LIVE && stat.key_match) begin
          cmd.step = 1'b0;
          if (stat.command == lphm_pkg::CMD_INSERT) begin
            cmd.write_val = 1'b1;
            cmd.status    = lphm_pkg::ST_DONE;
            state_next    = S_WRITE;
          end else if (stat.command == lphm_pkg::CMD_REMOVE) begin
            cmd.write_tomb = 1'b1;
            cmd.count_down = 1'b1;
            cmd.status     = lphm_pkg::ST_DONE;
            state_next     = S_WRITE;
          end else begin
            cmd.value_hit  = 1'b1;
            cmd.set_result = 1'b1;
            cmd.status     = lphm_pkg::ST_DONE;
            state_next     = S_IDLE;
          end
        end else if (stat.mark == lphm_pkg::MARK_EMPTY || stat.last_probe) begin
          cmd.step = 1'b0;
          if (stat.mark == lphm_pkg::MARK_TOMB && !tomb_seen) begin
            cmd.note_tomb = 1'b1;
          end
          if (stat.command == lphm_pkg::CMD_INSERT) begin
            if (stat.mark == lphm_pkg::MARK_EMPTY) begin
              // an empty slot wins over any tombstone passed
              cmd.write_live = 1'b1;
              cmd.use_tomb   = 1'b0;
              cmd.count_up   = 1'b1;
              cmd.status     = lphm_pkg::ST_DONE;
              state_next     = S_WRITE;
            end else if (tomb_seen || stat.mark == lphm_pkg::MARK_TOMB) begin
              cmd.write_live = 1'b1;
              cmd.use_tomb   = tomb_seen;
              cmd.count_up   = 1'b1;
              cmd.status     = lphm_pkg::ST_DONE;
              state_next     = S_WRITE;
            end else begin
              cmd.set_result = 1'b1;
              cmd.status     = lphm_pkg::ST_FULL;
              state_next     = S_IDLE;
            end
          end else begin
            cmd.set_result = 1'b1;
            cmd.status     = lphm_pkg::ST_MISS;
            state_next     = S_IDLE;
          end
        end else if (stat.mark == lphm_pkg::MARK_TOMB && !tomb_seen) begin
          cmd.note_tomb  = 1'b1;
          tomb_seen_next = 1'b1;
        end
      end
      S_WRITE: begin
        // slot writes and the count update were issued from S_CHECK; the result is raised here
        cmd.set_result = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

@@ rtl/lphm_dp.sv @@
// datapath: slot memories, probe index, count and result registers
module lphm_dp #(
  parameter int CAPACITY   = 32,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            command,
  input  logic [31:0]           key,
  input  logic [31:0]           key_hash,
  input  logic [31:0]           value_in,
  input  lphm_pkg::lphm_cmd_t   cmd,
  output lphm_pkg::lphm_stat_t  stat,
  output logic                  clear_done,
  output logic [1:0]            status,
  output logic [31:0]           value_out,
  output logic [5:0]            entry_count
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KSH = 32 + IW;
  // ceil(2^KSH / CAPACITY) gives the exact quotient for every 32-bit hash
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << KSH) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY);
  localparam logic [33:0] RECIP = RECIP_FULL[33:0];

  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_val;
  logic [1:0]            req_cmd;
  logic [31:0]           req_hash;
  logic [65:0]           hprod;
  logic [31:0]           hquot;
  logic [31:0]           hrem;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         tomb_idx;
  logic [CW-1:0]         probes;
  logic [CW-1:0]         live_count;
  logic [IW:0]           clr_idx;
  logic                  clearing;

  logic [IW-1:0]         start_idx;
  logic [1:0]            mark_rd;
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;

  logic                  mark_we;
  logic [IW-1:0]         mark_wa;
  logic [1:0]            mark_wd;
  logic                  kv_we;
  logic [IW-1:0]         kv_wa;
  logic [VALUE_BITS-1:0] val_wd;

  // hash modulo capacity: registered reciprocal product, then multiply back and subtract
  always_comb begin
    hquot     = 32'(hprod >> KSH);
    hrem      = req_hash - hquot * 32'(CAPACITY);
    start_idx = hrem[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_key  <= KEY_BITS'({32'd0, key});
      req_val  <= VALUE_BITS'(value_in);
      req_cmd  <= command;
      req_hash <= key_hash;
    end
    hprod <= 66'(req_hash) * 66'(RECIP);
    if (cmd.note_tomb) begin
      tomb_idx <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      probes     <= '0;
      live_count <= '0;
      clr_idx    <= '0;
      clearing   <= 1'b1;
      status     <= lphm_pkg::ST_DONE;
      value_out  <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == (IW+1)'(CAPACITY - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (cmd.start) begin
        idx    <= start_idx;
        probes <= CW'(1);
      end else if (cmd.step) begin
        idx    <= (idx == IW'(CAPACITY - 1)) ? '0 : idx + 1'b1;
        probes <= probes + 1'b1;
      end
      if (cmd.count_up) begin
        live_count <= live_count + 1'b1;
      end else if (cmd.count_down) begin
        live_count <= live_count - 1'b1;
      end
      if (cmd.write_live || cmd.write_val || cmd.write_tomb || cmd.set_result) begin
        if (!(cmd.set_result && !cmd.write_live && !cmd.write_val && !cmd.write_tomb
              && cmd.status == lphm_pkg::ST_DONE && !cmd.value_hit)) begin
          status <= cmd.status;
        end
        value_out <= cmd.value_hit ? 32'(val_rd) : 32'd0;
      end
    end
  end

  assign clear_done = !clearing;

  always_comb begin
    mark_we = 1'b0;
    mark_wa = idx;
    mark_wd = lphm_pkg::MARK_LIVE;
    kv_we   = 1'b0;
    kv_wa   = idx;
    val_wd  = req_val;
    if (clearing) begin
      mark_we = 1'b1;
      mark_wa = clr_idx[IW-1:0];
      mark_wd = lphm_pkg::MARK_EMPTY;
    end else if (cmd.write_live) begin
      mark_we = 1'b1;
      kv_we   = 1'b1;
      if (cmd.use_tomb || cmd.note_tomb) begin
        mark_wa = cmd.use_tomb ? tomb_idx : idx;
        kv_wa   = mark_wa;
      end
    end else if (cmd.write_tomb) begin
      mark_we = 1'b1;
      mark_wd = lphm_pkg::MARK_TOMB;
    end else if (cmd.write_val) begin
      kv_we = 1'b1;
    end
  end

  lphm_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
    .raddr(idx), .rdata(mark_rd)
  );

  lphm_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key (
    .clk(clk), .we(kv_we && cmd.write_live), .waddr(kv_wa), .wdata(req_key),
    .raddr(idx), .rdata(key_rd)
  );

  lphm_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val (
    .clk(clk), .we(kv_we), .waddr(kv_wa), .wdata(val_wd),
    .raddr(idx), .rdata(val_rd)
  );

  assign stat.command    = req_cmd;
  assign stat.mark       = mark_rd;
  assign stat.key_match  = (key_rd == req_key);
  assign stat.last_probe = (probes == CW'(CAPACITY));
  assign entry_count     = 6'(live_count);

endmodule
